@@ rtl/core/ipv4lpm_pkg.sv @@
package ipv4lpm_pkg;

  // Default depth of the route table, one cell per entry.
  localparam int unsigned DEF_ROUTE_ENTRIES = 64;

  // Field widths.
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned LEN_W  = 6;
  localparam int unsigned WORD_W = 16;
  localparam int unsigned TTL_W  = 8;
  // A folded ones-complement sum never exceeds 17'h10000.
  localparam int unsigned SUM_W  = WORD_W + 1;
  localparam int unsigned IDX_W  = 5;

  // Longest legal prefix.
  localparam logic [LEN_W-1:0] MAX_PREFIX_LEN = LEN_W'(32);

  // Header word positions of interest.
  localparam logic [IDX_W-1:0] WORD_TTL    = IDX_W'(4);
  localparam logic [IDX_W-1:0] WORD_CSUM   = IDX_W'(5);
  localparam logic [IDX_W-1:0] WORD_DST_HI = IDX_W'(8);
  localparam logic [IDX_W-1:0] WORD_DST_LO = IDX_W'(9);
  localparam logic [IDX_W-1:0] WORD_IDX_MAX = IDX_W'(31);

  // Input commands.
  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_HDR   = 2'd2
  } cmd_e;

  // Decisions.
  typedef enum logic [1:0] {
    ACT_LOCAL    = 2'd0,
    ACT_FORWARD  = 2'd1,
    ACT_NO_ROUTE = 2'd2,
    ACT_TTL      = 2'd3
  } act_e;

  typedef struct packed {
    logic [1:0]        command;
    logic [ADDR_W-1:0] route_dest;
    logic [LEN_W-1:0]  route_mask_len;
    logic [ADDR_W-1:0] route_next_hop;
    logic [WORD_W-1:0] header_word;
    logic              header_last;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [ADDR_W-1:0] next_hop;
    logic [TTL_W-1:0]  new_ttl;
    logic [WORD_W-1:0] new_checksum;
  } out_item_t;

  // One stored route.
  typedef struct packed {
    logic [ADDR_W-1:0] prefix;
    logic [LEN_W-1:0]  len;
    logic [ADDR_W-1:0] hop;
  } route_t;

  // Lookup token that walks the cell chain.
  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] dest;
    logic [TTL_W-1:0]  ttl;
    logic [SUM_W-1:0]  sum;
    logic              found;
    logic [LEN_W-1:0]  best_len;
    logic [ADDR_W-1:0] best_hop;
  } srch_t;

  // Network mask for a prefix length of 0 to 32.
  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
    return ~({ADDR_W{1'b1}} >> len);
  endfunction

endpackage

@@ rtl/core/ipv4lpm_hdr.sv @@
module ipv4lpm_hdr (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            word_en_i,
  input  logic [ipv4lpm_pkg::WORD_W-1:0]  word_i,
  input  logic                            last_i,
  output ipv4lpm_pkg::srch_t              srch_o
);
  import ipv4lpm_pkg::*;

  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [ADDR_W-1:0] dest_q, dest_d;
  logic [TTL_W-1:0]  ttl_q, ttl_d;
  logic [WORD_W-1:0] add;
  logic [SUM_W-1:0]  raw;
  logic [SUM_W-1:0]  fold;

  // Pick out TTL and destination, and form the word that enters the checksum.
  always_comb begin
    ttl_d  = ttl_q;
    dest_d = dest_q;
    add    = word_i;
    case (idx_q)
      WORD_TTL: begin
        ttl_d = word_i[15:8];
        add   = {word_i[15:8] - 8'd1, word_i[7:0]};
      end
      WORD_CSUM: begin
        add = '0;
      end
      WORD_DST_HI: begin
        dest_d = {word_i, dest_q[15:0]};
      end
      WORD_DST_LO: begin
        dest_d = {dest_q[31:16], word_i};
      end
      default: begin
      end
    endcase
  end

  // Ones-complement add with end-around carry.
  assign raw  = sum_q + SUM_W'(add);
  assign fold = SUM_W'(raw[WORD_W-1:0]) + SUM_W'(raw[WORD_W]);

  always_comb begin
    sum_d = fold;
    idx_d = (idx_q < WORD_IDX_MAX) ? idx_q + IDX_W'(1) : idx_q;
  end

  // Header state returns to zero after the last word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      sum_q  <= '0;
      dest_q <= '0;
      ttl_q  <= '0;
    end else if (word_en_i) begin
      if (last_i) begin
        idx_q  <= '0;
        sum_q  <= '0;
        dest_q <= '0;
        ttl_q  <= '0;
      end else begin
        idx_q  <= idx_d;
        sum_q  <= sum_d;
        dest_q <= dest_d;
        ttl_q  <= ttl_d;
      end
    end
  end

  // Launch a lookup token with the final header values.
  always_comb begin
    srch_o          = '0;
    srch_o.valid    = word_en_i && last_i;
    srch_o.dest     = dest_d;
    srch_o.ttl      = ttl_d;
    srch_o.sum      = sum_d;
    srch_o.found    = 1'b0;
    srch_o.best_len = '0;
    srch_o.best_hop = '0;
  end

endmodule

@@ rtl/core/ipv4lpm_cell.sv @@
module ipv4lpm_cell #(
  parameter int unsigned INDEX   = 0,
  parameter int unsigned COUNT_W = 7
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic                 wr_en_i,
  input  ipv4lpm_pkg::route_t  wr_route_i,
  input  logic [COUNT_W-1:0]   count_i,
  input  ipv4lpm_pkg::srch_t   srch_i,
  output ipv4lpm_pkg::srch_t   srch_o
);
  import ipv4lpm_pkg::*;

  route_t route_q;
  srch_t  srch_d, data_q;
  logic   valid_q;
  logic   live;
  logic   hit;

  // This cell owns the entry at its own position in the table.
  always_ff @(posedge clk_i) begin
    if (wr_en_i && (count_i == COUNT_W'(INDEX))) begin
      route_q <= wr_route_i;
    end
  end

  // Only entries below the fill count take part in a lookup.
  assign live = COUNT_W'(INDEX) < count_i;
  assign hit  = srch_i.valid && live &&
                ((srch_i.dest & prefix_mask(route_q.len)) == route_q.prefix) &&
                (!srch_i.found || (route_q.len > srch_i.best_len));

  always_comb begin
    srch_d = srch_i;
    if (hit) begin
      srch_d.found    = 1'b1;
      srch_d.best_len = route_q.len;
      srch_d.best_hop = route_q.hop;
    end
  end

  // Hand the token to the next cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= srch_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      data_q <= srch_d;
    end
  end

  always_comb begin
    srch_o       = data_q;
    srch_o.valid = valid_q;
  end

endmodule

@@ rtl/core/ipv4_forward_longest_prefix_top.sv @@
// IPv4 forwarding decision with a longest-prefix route table held in a chain
// of ROUTE_ENTRIES cells, one route per cell. Clear, add-route and header-word
// transfers are taken one per cycle. The last header word launches a lookup
// token that moves one cell per cycle through the whole chain while the chain
// is not stalled by a result that cannot leave; the result is registered at
// the chain end, and input ready is low while the token is in the chain.
// A route is added at the position given by the fill count; adds to a full
// table are dropped, and clear only resets the fill count.
module ipv4_forward_longest_prefix_top #(
  parameter int unsigned ROUTE_ENTRIES = ipv4lpm_pkg::DEF_ROUTE_ENTRIES
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  ipv4lpm_pkg::in_item_t          in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output ipv4lpm_pkg::out_item_t         out_data_o,
  input  logic                           cfg_we_i,
  input  logic [ipv4lpm_pkg::ADDR_W-1:0] cfg_wdata_i
);
  import ipv4lpm_pkg::*;

  localparam int unsigned COUNT_W = $clog2(ROUTE_ENTRIES + 1);

  logic [ADDR_W-1:0]  local_q;
  logic [COUNT_W-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_q, out_d;
  logic               in_xfer;
  logic               hdr_en;
  logic               add_en;
  logic               adv;
  logic [LEN_W-1:0]   len_sat;
  route_t             wr_route;
  srch_t              link [ROUTE_ENTRIES+1];
  srch_t              tail;

  assign in_xfer    = in_valid_i && in_ready_o;
  assign in_ready_o = !busy_q;
  assign hdr_en     = in_xfer && (in_data_i.command == CMD_HDR);
  assign add_en     = in_xfer && (in_data_i.command == CMD_ADD) &&
                      (cnt_q < COUNT_W'(ROUTE_ENTRIES));

  // Local address register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_q <= '0;
    end else if (cfg_we_i) begin
      local_q <= cfg_wdata_i;
    end
  end

  // Route to store: length saturated, prefix masked to it.
  always_comb begin
    len_sat = (in_data_i.route_mask_len > MAX_PREFIX_LEN) ?
              MAX_PREFIX_LEN : in_data_i.route_mask_len;
    wr_route.prefix = in_data_i.route_dest & prefix_mask(len_sat);
    wr_route.len    = len_sat;
    wr_route.hop    = in_data_i.route_next_hop;
  end

  // Fill count.
  always_comb begin
    cnt_d = cnt_q;
    if (in_xfer && (in_data_i.command == CMD_CLEAR)) begin
      cnt_d = '0;
    end else if (add_en) begin
      cnt_d = cnt_q + COUNT_W'(1);
    end
  end

  // Header parsing and token launch.
  ipv4lpm_hdr u_hdr (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .word_en_i (hdr_en),
    .word_i    (in_data_i.header_word),
    .last_i    (in_data_i.header_last),
    .srch_o    (link[0])
  );

  // The chain stalls only when a finished token cannot leave.
  assign tail = link[ROUTE_ENTRIES];
  assign adv  = !(tail.valid && out_valid_q && !out_ready_i);

  for (genvar i = 0; i < ROUTE_ENTRIES; i++) begin : g_cell
    ipv4lpm_cell #(
      .INDEX   (i),
      .COUNT_W (COUNT_W)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .adv_i      (adv),
      .wr_en_i    (add_en),
      .wr_route_i (wr_route),
      .count_i    (cnt_q),
      .srch_i     (link[i]),
      .srch_o     (link[i+1])
    );
  end

  // Decision at the end of the chain.
  always_comb begin
    out_d              = '0;
    out_d.new_ttl      = tail.ttl;
    if (tail.dest == local_q) begin
      out_d.action = ACT_LOCAL;
    end else if (!tail.found) begin
      out_d.action = ACT_NO_ROUTE;
    end else if (tail.ttl <= TTL_W'(1)) begin
      out_d.action = ACT_TTL;
    end else begin
      out_d.action       = ACT_FORWARD;
      out_d.next_hop     = tail.best_hop;
      out_d.new_ttl      = tail.ttl - TTL_W'(1);
      out_d.new_checksum = ~tail.sum[WORD_W-1:0];
    end
  end

  // Busy from the launching transfer until the token leaves the chain.
  always_comb begin
    busy_d = busy_q;
    if (hdr_en && in_data_i.header_last) begin
      busy_d = 1'b1;
    end else if (tail.valid && adv) begin
      busy_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (tail.valid && adv) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (tail.valid && adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // No token may reach the end of the chain unless a lookup is in flight.
  a_tail_needs_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> !tail.valid)
    else $error("lookup token without a lookup in flight");

  // The fill count never passes the table depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= COUNT_W'(ROUTE_ENTRIES))
    else $error("route count beyond table depth");

  // A new result only ever comes from a token at the chain end.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(tail.valid))
    else $error("result without a finished lookup");

  // The table is not written while a lookup walks the chain.
  a_no_write_in_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !add_en)
    else $error("route added during a lookup");
`endif

endmodule
